// File: rtl/core/fenwick_range_add_range_sum_core_defines.svh
// Assertion macros shared by the range-add / range-sum core files
`ifndef FENWICK_RANGE_ADD_RANGE_SUM_CORE_DEFINES_SVH
`define FENWICK_RANGE_ADD_RANGE_SUM_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst_n is low
`define FRARS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define FRARS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FRARS_ASSERT_IMP(lbl, ante, cons)
`define FRARS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/frars_pkg.sv
// Shared constants and types of the range-add / range-sum core
package frars_pkg;

    localparam int NUM_ELEMENTS = 1024;
    localparam int ADDR_W       = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int NODE_W       = ADDR_W + 2;
    localparam int IDX_W        = 10;
    localparam int POS_W        = IDX_W + 1;
    localparam int VAL_W        = 32;
    localparam int RAM_W        = 2 * VAL_W;
    localparam int S_FIELD_W    = 2 * IDX_W + VAL_W;
    localparam int S_DATA_W     = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W     = VAL_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0]       N_U    = 32'(NUM_ELEMENTS);
    localparam logic [NODE_W-1:0] NODE_N = NODE_W'(NUM_ELEMENTS);

    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_SUM = 1'b1
    } cmd_t;

    // one classified command: two point updates or two prefix walks
    typedef struct packed {
        cmd_t               cmd;
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
        logic               skip_a;
        logic               skip_b;
        logic [VAL_W-1:0]   amount;
    } cmd_ent_t;

    // tree memory port group; data word is {weighted, delta}
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [RAM_W-1:0]   wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

// File: rtl/core/fenwick_range_add_range_sum_core.sv
// Top level of the range-add / range-sum core over two binary indexed trees
//
// channel   dir  handshake          tdata (low bit up)                         tuser
// s_*       in   s_tvalid/s_tready  left_index[9:0] right_index[19:10]         cmd
//                                   add_value[51:20], zero pad [55:52]
// m_*       out  m_tvalid/m_tready  range_total[31:0]                          -
//
// In the tree engine an add or a query makes one memory read per tree node,
// pipelined one node per cycle.
// The input stage and a two-entry queue take further commands while the engine works.
// After reset a clearing pass writes zeros over all N tree words with s_tready low.
// A waiting result sits in the output register and stalls the engine only at its last step.
module fenwick_range_add_range_sum_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [frars_pkg::S_DATA_W-1:0] s_tdata,   // left_index, right_index, add_value
    input  logic [0:0]                     s_tuser,   // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [frars_pkg::M_DATA_W-1:0] m_tdata    // range_total
);
    import frars_pkg::*;

    logic             clear_busy;
    logic             fq_valid;
    logic             fq_ready;
    cmd_ent_t         fq_data;
    logic             qb_valid;
    logic             qb_ready;
    cmd_ent_t         qb_data;
    ram_req_t         ram;
    logic [RAM_W-1:0] ram_rd_data;

    frars_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_busy (clear_busy),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    frars_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    frars_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .clear_busy  (clear_busy),
        .ram         (ram),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    frars_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (ram.wr_en),
        .wr_addr (ram.wr_addr),
        .wr_data (ram.wr_data),
        .rd_en   (ram.rd_en),
        .rd_addr (ram.rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// File: rtl/core/frars_ram.sv
// Generic simple dual-port RAM with registered read
module frars_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/frars_front.sv
// Input stage: takes commands and turns them into point-update / prefix-walk pairs
module frars_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [frars_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          clear_busy,
    output logic                          q_valid,
    input  logic                          q_ready,
    output frars_pkg::cmd_ent_t           q_data
);
    import frars_pkg::*;

    logic             ent_valid_reg;
    logic             ent_valid_next;
    cmd_ent_t         ent_reg;
    cmd_ent_t         ent_next;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] right_inc;
    logic             accept;

    always_comb
    begin
        left_idx  = s_tdata[IDX_W-1:0];
        right_idx = s_tdata[2*IDX_W-1:IDX_W];
        value     = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
        right_inc = {1'b0, right_idx} + POS_W'(1);

        s_tready = !clear_busy && (!ent_valid_reg || q_ready);
        accept   = s_tvalid && s_tready;

        ent_next       = ent_reg;
        ent_valid_next = ent_valid_reg;
        if (ent_valid_reg && q_ready)
        begin
            ent_valid_next = 1'b0;
        end
        if (accept)
        begin
            ent_valid_next = 1'b1;
            ent_next.cmd   = cmd_t'(s_tuser[0]);
            ent_next.amount = value;
            unique case (cmd_t'(s_tuser[0]))
                CMD_SUM:
                begin
                    // P(right+1) - P(left)
                    ent_next.pos_a  = right_inc;
                    ent_next.pos_b  = {1'b0, left_idx};
                    ent_next.skip_a = 1'b0;
                    ent_next.skip_b = 1'b0;
                end
                CMD_ADD:
                begin
                    // +v at left, -v at right+1; positions past the store do nothing
                    ent_next.pos_a  = {1'b0, left_idx};
                    ent_next.pos_b  = right_inc;
                    ent_next.skip_a = (32'(left_idx) >= N_U);
                    ent_next.skip_b = (32'(right_inc) >= N_U);
                end
                default:
                begin
                    ent_next = ent_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign q_valid = ent_valid_reg;
    assign q_data  = ent_reg;

endmodule

// File: rtl/core/frars_queue.sv
// Short command queue between the input stage and the tree engine
`include "fenwick_range_add_range_sum_core_defines.svh"

module frars_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  frars_pkg::cmd_ent_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output frars_pkg::cmd_ent_t pop_data
);
    import frars_pkg::*;

    cmd_ent_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    always_comb
    begin
        push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
        pop_valid  = (count_reg != '0);
        push       = push_valid && push_ready;
        pop        = pop_valid && pop_ready;
        pop_data   = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `FRARS_ASSERT_NXT(a_q_count_up, (push && !pop), (count_reg == $past(count_reg) + 1'b1))

endmodule

// File: rtl/core/frars_back.sv
// Tree engine: clearing pass, point-update and prefix-walk sequencing, result register
`include "fenwick_range_add_range_sum_core_defines.svh"

module frars_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  frars_pkg::cmd_ent_t           q_data,
    output logic                          clear_busy,
    output frars_pkg::ram_req_t           ram,
    input  logic [frars_pkg::RAM_W-1:0]   ram_rd_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [frars_pkg::M_DATA_W-1:0] m_tdata
);
    import frars_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_MUL,
        ST_SUM
    } state_t;

    state_t            state_reg,     state_next;
    cmd_ent_t          ent_reg,       ent_next;
    logic              second_reg,    second_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [VAL_W-1:0]  amt_reg,       amt_next;
    logic [VAL_W-1:0]  scaled_reg,    scaled_next;
    logic [NODE_W-1:0] node_reg,      node_next;
    logic              pend_reg,      pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [VAL_W-1:0]  s0_reg,        s0_next;
    logic [VAL_W-1:0]  s1_reg,        s1_next;
    logic [VAL_W-1:0]  prod_reg,      prod_next;
    logic [VAL_W-1:0]  p_first_reg,   p_first_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_data_reg,  out_data_next;
    logic [ADDR_W-1:0] clr_addr_reg,  clr_addr_next;

    logic              is_upd;
    logic [POS_W-1:0]  cur_pos;
    logic              cur_skip;
    logic [VAL_W-1:0]  cur_amt;
    logic [NODE_W-1:0] start_node;
    logic [NODE_W-1:0] low_bit;
    logic              issue;
    logic [VAL_W-1:0]  p_val;

    always_comb
    begin
        is_upd   = (ent_reg.cmd == CMD_ADD);
        cur_pos  = second_reg ? ent_reg.pos_b : ent_reg.pos_a;
        cur_skip = second_reg ? ent_reg.skip_b : ent_reg.skip_a;
        cur_amt  = second_reg ? (VAL_W'(0) - ent_reg.amount) : ent_reg.amount;
        // walk start is clipped to the store size; the multiplier keeps cur_pos
        start_node = ((32'(cur_pos) + 32'd1) > N_U) ? NODE_N
                                                     : NODE_W'(cur_pos) + NODE_W'(1);
        low_bit  = node_reg & (~node_reg + NODE_W'(1));
        issue    = (state_reg == ST_WALK) &&
                   (is_upd ? (node_reg <= NODE_N) : (node_reg != '0));
        p_val    = prod_reg - s1_reg;

        state_next     = state_reg;
        ent_next       = ent_reg;
        second_next    = second_reg;
        pos_next       = pos_reg;
        amt_next       = amt_reg;
        scaled_next    = scaled_reg;
        node_next      = node_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        prod_next      = prod_reg;
        p_first_next   = p_first_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        clr_addr_next  = clr_addr_reg;

        q_ready     = (state_reg == ST_IDLE);
        ram.wr_en   = 1'b0;
        ram.wr_addr = pend_addr_reg;
        ram.wr_data = {ram_rd_data[RAM_W-1:VAL_W] + scaled_reg,
                       ram_rd_data[VAL_W-1:0] + amt_reg};
        ram.rd_en   = issue;
        ram.rd_addr = ADDR_W'(node_reg - NODE_W'(1));

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram.wr_en     = 1'b1;
                ram.wr_addr   = clr_addr_reg;
                ram.wr_data   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(NUM_ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    ent_next    = q_data;
                    second_next = 1'b0;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (is_upd && cur_skip)
                begin
                    second_next = 1'b1;
                    state_next  = second_reg ? ST_IDLE : ST_SETUP;
                end
                else
                begin
                    node_next   = start_node;
                    pos_next    = cur_pos;
                    amt_next    = cur_amt;
                    scaled_next = cur_amt * VAL_W'(cur_pos);
                    s0_next     = '0;
                    s1_next     = '0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // a read goes out every cycle; its data is used in the cycle after
                if (issue)
                begin
                    node_next      = is_upd ? node_reg + low_bit : node_reg - low_bit;
                    pend_next      = 1'b1;
                    pend_addr_next = ram.rd_addr;
                end
                if (pend_reg)
                begin
                    if (is_upd)
                    begin
                        ram.wr_en = 1'b1;
                    end
                    else
                    begin
                        s0_next = s0_reg + ram_rd_data[VAL_W-1:0];
                        s1_next = s1_reg + ram_rd_data[RAM_W-1:VAL_W];
                    end
                end
                if (!issue && !pend_reg)
                begin
                    if (is_upd)
                    begin
                        second_next = 1'b1;
                        state_next  = second_reg ? ST_IDLE : ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = s0_reg * VAL_W'(pos_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!second_reg)
                begin
                    p_first_next = p_val;
                    second_next  = 1'b1;
                    state_next   = ST_SETUP;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = p_first_reg - p_val;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ent_reg       <= '0;
            second_reg    <= 1'b0;
            pos_reg       <= '0;
            amt_reg       <= '0;
            scaled_reg    <= '0;
            node_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            prod_reg      <= '0;
            p_first_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ent_reg       <= ent_next;
            second_reg    <= second_next;
            pos_reg       <= pos_next;
            amt_reg       <= amt_next;
            scaled_reg    <= scaled_next;
            node_reg      <= node_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            s0_reg        <= s0_next;
            s1_reg        <= s1_next;
            prod_reg      <= prod_next;
            p_first_reg   <= p_first_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    assign clear_busy = (state_reg == ST_CLEAR);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    `FRARS_ASSERT_IMP(a_no_rw_collide, (ram.wr_en && ram.rd_en), (ram.wr_addr != ram.rd_addr))
    `FRARS_ASSERT_IMP(a_clear_no_item, (state_reg == ST_CLEAR), (!q_ready && !out_valid_reg))
    `FRARS_ASSERT_IMP(a_result_from_sum, $rose(out_valid_reg), (($past(state_reg) == ST_SUM) && $past(second_reg)))

endmodule
